FILE: sv/base64_osc52_encoder_core_macros.svh
// Assertion helpers used by the encoder back end.
`ifndef BASE64_OSC52_ENCODER_CORE_MACROS_SVH
`define BASE64_OSC52_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define B64OSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("b64osc: property failed");
`define B64OSC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("b64osc: forbidden condition seen");
`else
`define B64OSC_ASSERT(lbl, clk, rst_n, prop)
`define B64OSC_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: sv/b64osc_pkg.sv
package b64osc_pkg;

  localparam int unsigned DefaultQueueDepth = 2;

  localparam logic FrameEnableReset = 1'b1;

  localparam logic [7:0] PadChar = 8'h3D;
  localparam logic [7:0] BelChar = 8'h07;

  // Emission positions within one job: prefix, base64 group, terminator.
  localparam logic [3:0] PosPrefixFirst = 4'd0;
  localparam logic [3:0] PosPrefixLast  = 4'd6;
  localparam logic [3:0] PosGroupFirst  = 4'd7;
  localparam logic [3:0] PosGroupLast   = 4'd10;
  localparam logic [3:0] PosBel         = 4'd11;

  // One request for the back end: what to emit for one accepted byte.
  typedef struct packed {
    logic        prefix;
    logic        group;
    logic [2:0]  nsym;   // symbols before padding, 2..4
    logic [23:0] word;
    logic        bel;
  } job_t;

  function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    if (idx < 6'd26) begin
      return 8'(8'd65 + wide);
    end else if (idx < 6'd52) begin
      return 8'(8'd97 + wide - 8'd26);
    end else if (idx < 6'd62) begin
      return 8'(8'd48 + wide - 8'd52);
    end else if (idx == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  function automatic logic [7:0] osc_prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h1B;
      3'd1:    ch = 8'h5D;
      3'd2:    ch = 8'h35;
      3'd3:    ch = 8'h32;
      3'd4:    ch = 8'h3B;
      3'd5:    ch = 8'h63;
      3'd6:    ch = 8'h3B;
      default: ch = 8'h3B;
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/b64osc_front.sv
module b64osc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              full_i,
  output logic              push_o,
  output b64osc_pkg::job_t  job_o
);
  import b64osc_pkg::*;

  logic        frame_enable_q;
  logic [15:0] held_bytes_q, held_bytes_d;
  logic [1:0]  held_count_q, held_count_d;
  logic        in_message_q, in_message_d;

  logic        accept;
  logic [15:0] held_after;
  logic [1:0]  cnt_after;
  job_t        job;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    job          = '0;
    job.prefix   = !in_message_q && frame_enable_q;
    held_after   = '0;
    cnt_after    = 2'd0;
    if (held_count_q == 2'd2) begin
      job.group  = 1'b1;
      job.nsym   = 3'd4;
      job.word   = {held_bytes_q, data_byte_i};
    end else begin
      held_after = {held_bytes_q[7:0], data_byte_i};
      cnt_after  = 2'(held_count_q + 2'd1);
    end

    held_bytes_d = held_after;
    held_count_d = cnt_after;
    in_message_d = 1'b1;
    if (last_byte_i) begin
      // Flush the partial group with padding, close the frame.
      if (cnt_after == 2'd1) begin
        job.group = 1'b1;
        job.nsym  = 3'd2;
        job.word  = {held_after[7:0], 16'h0000};
      end else if (cnt_after == 2'd2) begin
        job.group = 1'b1;
        job.nsym  = 3'd3;
        job.word  = {held_after, 8'h00};
      end
      job.bel      = frame_enable_q;
      held_bytes_d = '0;
      held_count_d = 2'd0;
      in_message_d = 1'b0;
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.prefix || job.group || job.bel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_enable_q <= FrameEnableReset;
      held_bytes_q   <= '0;
      held_count_q   <= 2'd0;
      in_message_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_enable_q <= cfg_wdata_i;
      end
      if (accept) begin
        held_bytes_q <= held_bytes_d;
        held_count_q <= held_count_d;
        in_message_q <= in_message_d;
      end
    end
  end

endmodule

FILE: sv/b64osc_fifo.sv
module b64osc_fifo #(
  parameter int unsigned Depth = b64osc_pkg::DefaultQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  b64osc_pkg::job_t  job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output b64osc_pkg::job_t  job_o
);
  import b64osc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign job_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= CntW'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= CntW'(count_q - 1'b1);
      end
    end
  end

endmodule

FILE: sv/b64osc_back.sv
`include "base64_osc52_encoder_core_macros.svh"

module b64osc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  b64osc_pkg::job_t  job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_char_o,
  output logic              run_last_o
);
  import b64osc_pkg::*;

  logic       started_q;
  logic [3:0] pos_q;
  logic       out_valid_q;
  logic [7:0] out_char_q;
  logic       run_last_q;

  logic       emit;
  logic       at_end;
  logic [3:0] cur_pos, next_pos, slot_off;
  logic [1:0] slot;
  logic [5:0] sym_idx;
  logic [7:0] ch;

  assign emit = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    if (started_q) begin
      cur_pos = pos_q;
    end else if (job_i.prefix) begin
      cur_pos = PosPrefixFirst;
    end else if (job_i.group) begin
      cur_pos = PosGroupFirst;
    end else begin
      cur_pos = PosBel;
    end

    if (cur_pos == PosPrefixLast) begin
      next_pos = job_i.group ? PosGroupFirst : PosBel;
    end else begin
      next_pos = 4'(cur_pos + 4'd1);
    end

    at_end = (cur_pos == PosPrefixLast && !job_i.group && !job_i.bel)
          || (cur_pos == PosGroupLast && !job_i.bel)
          || (cur_pos == PosBel);

    slot_off = 4'(cur_pos - PosGroupFirst);
    slot     = slot_off[1:0];
    case (slot)
      2'd0:    sym_idx = job_i.word[23:18];
      2'd1:    sym_idx = job_i.word[17:12];
      2'd2:    sym_idx = job_i.word[11:6];
      default: sym_idx = job_i.word[5:0];
    endcase

    if (cur_pos <= PosPrefixLast) begin
      ch = osc_prefix_char(cur_pos[2:0]);
    end else if (cur_pos <= PosGroupLast) begin
      ch = ({1'b0, slot} < job_i.nsym) ? b64_symbol(sym_idx) : PadChar;
    end else begin
      ch = BelChar;
    end
  end

  assign pop_o = emit && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      pos_q       <= PosPrefixFirst;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        started_q   <= !at_end;
        pos_q       <= next_pos;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= ch;
      run_last_q <= at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;

  `B64OSC_ASSERT(a_prefix_needs_flag, clk_i, rst_ni, (emit && cur_pos <= PosPrefixLast) |-> job_i.prefix)
  `B64OSC_ASSERT(a_group_needs_flag, clk_i, rst_ni, (emit && cur_pos >= PosGroupFirst && cur_pos <= PosGroupLast) |-> job_i.group)
  `B64OSC_ASSERT(a_pop_marks_last, clk_i, rst_ni, pop_o |=> (out_valid_o && run_last_o))
  `B64OSC_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, emit && out_valid_q && !out_ready_i)

endmodule

FILE: sv/base64_osc52_encoder_core.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   data_byte_i, last_byte_i
// out       output     out_valid_o / out_ready_i out_char_o, run_last_o
// cfg       input      cfg_we_i                  cfg_wdata_i (frame_enable)
//
// One character leaves per cycle while a job waits and the output is not stalled;
// a byte is taken every cycle while the job queue has room. The single output
// register sets the output pace.
// The first character of a byte passes the job queue, then the output register.
// Reset clears all control state at once; no clearing pass.
// A stalled output holds its character; the input stays open until QueueDepth
// job requests wait, counting the one being emitted.
module base64_osc52_encoder_core #(
  parameter int unsigned QueueDepth = b64osc_pkg::DefaultQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       run_last_o
);
  import b64osc_pkg::*;

  job_t push_job, head_job;
  logic push, pop, full, empty;

  b64osc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64osc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  b64osc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import b64osc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } enc_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       last_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       run_last_o;

  // Encoder state as the testbench sees it.
  logic        framing_on;
  logic [15:0] pend_bytes;
  logic [1:0]  pend_count;
  logic        msg_open;

  enc_char_t pending_chars[$];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        error_count;

  string b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  logic [7:0] osc_lead [7] = '{8'h1B, 8'h5D, 8'h35, 8'h32, 8'h3B, 8'h63, 8'h3B};

  always #6 clk_i = ~clk_i;

  base64_osc52_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o)
  );

  function automatic logic [7:0] sextet_char(input logic [23:0] word, input int shift);
    logic [5:0] idx;
    idx = 6'((word >> shift) & 24'h3F);
    return b64_alpha[idx];
  endfunction

  // Work out the characters that one accepted byte produces and queue them.
  task automatic predict_chars(input logic [7:0] b, input logic is_last);
    logic [7:0]  chars[$];
    logic [23:0] word;
    enc_char_t   e;
    if (!msg_open) begin
      if (framing_on)
        for (int k = 0; k < 7; k++) chars.push_back(osc_lead[k]);
      msg_open = 1'b1;
    end
    if (pend_count >= 2) begin
      word = {pend_bytes, b};
      for (int s = 18; s >= 0; s -= 6) chars.push_back(sextet_char(word, s));
      pend_bytes = '0;
      pend_count = '0;
    end else begin
      pend_bytes = {pend_bytes[7:0], b};
      pend_count = pend_count + 2'd1;
    end
    if (is_last) begin
      if (pend_count == 2'd1) begin
        word = {pend_bytes[7:0], 16'h0000};
        chars.push_back(sextet_char(word, 18));
        chars.push_back(sextet_char(word, 12));
        chars.push_back(PadChar);
        chars.push_back(PadChar);
      end else if (pend_count == 2'd2) begin
        word = {pend_bytes, 8'h00};
        chars.push_back(sextet_char(word, 18));
        chars.push_back(sextet_char(word, 12));
        chars.push_back(sextet_char(word, 6));
        chars.push_back(PadChar);
      end
      if (framing_on) chars.push_back(BelChar);
      pend_bytes = '0;
      pend_count = '0;
      msg_open   = 1'b0;
    end
    for (int i = 0; i < chars.size(); i++) begin
      e.ch  = chars[i];
      e.fin = (i == chars.size() - 1);
      pending_chars.push_back(e);
    end
  endtask

  // Call at a falling edge; returns at a falling edge with valid still high.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_chars(b, is_last);
    @(negedge clk_i);
  endtask

  // Drop valid, let every queued character out, then give the back end time to settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_framing(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    framing_on  = v;
  endtask

  task automatic test_framed_groups();
    set_framing(1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_unframed();
    set_framing(1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_idle();
  endtask

  // Prefix and BEL follow the setting seen at the first and last byte.
  task automatic test_framing_switch();
    set_framing(1'b1);
    send_byte(8'h41, 1'b0);
    wait_idle();
    set_framing(1'b0);
    send_byte(8'h42, 1'b1);
    send_byte(8'h43, 1'b0);
    wait_idle();
    set_framing(1'b1);
    send_byte(8'h44, 1'b0);
    send_byte(8'h45, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_stream(input int n_items, input int idle_pct,
                                    input int stall_pct, input logic framing);
    int sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_framing(framing);
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), i == len - 1);
        sent++;
      end
    end
    wait_idle();
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin : check_out
    enc_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected char %h last %b", out_char_o, run_last_o);
      end else begin
        want = pending_chars.pop_front();
        if (want.ch !== out_char_o || want.fin !== run_last_o) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected char %h last %b, got char %h last %b",
                     want.ch, want.fin, out_char_o, run_last_o);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = 1'b0;
    in_valid_i     = 1'b0;
    data_byte_i    = '0;
    last_byte_i    = 1'b0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    framing_on     = FrameEnableReset;
    pend_bytes     = '0;
    pend_count     = '0;
    msg_open       = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_framed_groups();
    test_unframed();
    test_framing_switch();
    test_random_stream(26, 0, 0, 1'b1);
    test_random_stream(26, 56, 0, 1'b0);
    test_random_stream(26, 0, 56, 1'b1);
    test_random_stream(26, 35, 35, 1'($urandom_range(1)));

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/b64osc_pkg.sv
sv/b64osc_front.sv
sv/b64osc_fifo.sv
sv/b64osc_back.sv
sv/base64_osc52_encoder_core.sv
test/tb_top.sv
